[rtl/lbts_pkg.sv]
// Shared types and constants of the buffer tag store.
package lbts_pkg;

	localparam int DEF_ENTRIES  = 1024;
	localparam int DEF_TAG_BITS = 32;
	localparam int SLICE_W      = 32;
	localparam int IDX_W        = 10;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_ALLOC  = 2'd1,
		OP_BIND   = 2'd2
	} lbts_op_t;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_MISS = 1'b1;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [SLICE_W-1:0] slice_tag;
		logic [IDX_W-1:0]   entry_index;
	} lbts_req_t;

	typedef struct packed {
		logic             status;
		logic [IDX_W-1:0] buffer_index;
	} lbts_rsp_t;

endpackage

[rtl/lru_buffer_tag_store_unit.sv]
// Hashed LRU tag store: sequencer over the tag, recency and bucket chain memories.
//
//  Channel   Signals              Direction  Transaction
//  command   start, req           in         accepted when start is high and busy is low
//  response  done, rsp            out        valid for the single cycle done is high
//
// One transaction is handled at a time; busy stays high until its response is issued.
// A lookup reads its bucket head, walks the bucket chain comparing whole tags and
// moves a hit to the most recent end. Allocate moves the least recent entry there,
// drops it from its bucket chain if it still holds a tag and clears its tag. Bind
// unlinks the entry likewise, writes its tag and appends it to that tag's bucket
// unless it is the none marker. After reset a clearing pass writes every memory;
// busy is high meanwhile. The receiver cannot stall: each response is shown once.
module lru_buffer_tag_store_unit
	import lbts_pkg::*;
#(
	parameter int ENTRIES  = DEF_ENTRIES,
	parameter int TAG_BITS = DEF_TAG_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  lbts_req_t req,
	output logic      done,
	output lbts_rsp_t rsp
);

	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int IW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] NIL = IW'(ENTRIES);
	localparam logic [TAG_BITS-1:0] TAG_NONE = '1;
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	typedef enum logic [20:0] {
		S_CLEAR  = 21'h000001,
		S_IDLE   = 21'h000002,
		S_L_HEAD = 21'h000004,
		S_L_LOAD = 21'h000008,
		S_L_CHK  = 21'h000010,
		S_L_CMP  = 21'h000020,
		S_AL_RD  = 21'h000040,
		S_AL_TAG = 21'h000080,
		S_B_RD   = 21'h000100,
		S_B_TAG  = 21'h000200,
		S_M_RD   = 21'h000400,
		S_M_UNL  = 21'h000800,
		S_M_LNK1 = 21'h001000,
		S_M_LNK2 = 21'h002000,
		S_CR_RD  = 21'h004000,
		S_CR_UNL = 21'h008000,
		S_CR_CLR = 21'h010000,
		S_T_WR   = 21'h020000,
		S_A_RD   = 21'h040000,
		S_A_WR1  = 21'h080000,
		S_A_WR2  = 21'h100000
	} state_t;

	state_t state_q;
	logic [AW-1:0]       clr_q;
	logic [1:0]          op_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [TAG_BITS-1:0] oldtag_q;
	logic [IW-1:0]       e_q;
	logic [IW-1:0]       cur_q;
	logic [IW-1:0]       cnt_q;
	logic [IW-1:0]       t_q;
	logic [IW-1:0]       rhead_q;
	logic [IW-1:0]       rtail_q;
	logic                done_q;
	lbts_rsp_t           rsp_q;

	// Memory ports.
	logic                tag_we, rp_we, rn_we, cp_we, cn_we, bh_we, bt_we;
	logic [AW-1:0]       tag_wa, rp_wa, rn_wa, cp_wa, cn_wa, bh_wa, bt_wa;
	logic [AW-1:0]       tag_ra, rp_ra, rn_ra, cp_ra, cn_ra, bh_ra, bt_ra;
	logic [TAG_BITS-1:0] tag_wd, tag_rd;
	logic [IW-1:0]       rp_wd, rn_wd, cp_wd, cn_wd, bh_wd, bt_wd;
	logic [IW-1:0]       rp_rd, rn_rd, cp_rd, cn_rd, bh_rd, bt_rd;

	lbts_ram #(.WIDTH(TAG_BITS), .DEPTH(ENTRIES)) u_tag (.clk(clk), .we(tag_we),
		.waddr(tag_wa), .wdata(tag_wd), .raddr(tag_ra), .rdata(tag_rd));
	lbts_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rprev (.clk(clk), .we(rp_we),
		.waddr(rp_wa), .wdata(rp_wd), .raddr(rp_ra), .rdata(rp_rd));
	lbts_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_rnext (.clk(clk), .we(rn_we),
		.waddr(rn_wa), .wdata(rn_wd), .raddr(rn_ra), .rdata(rn_rd));
	lbts_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_cprev (.clk(clk), .we(cp_we),
		.waddr(cp_wa), .wdata(cp_wd), .raddr(cp_ra), .rdata(cp_rd));
	lbts_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_cnext (.clk(clk), .we(cn_we),
		.waddr(cn_wa), .wdata(cn_wd), .raddr(cn_ra), .rdata(cn_rd));
	lbts_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_bhead (.clk(clk), .we(bh_we),
		.waddr(bh_wa), .wdata(bh_wd), .raddr(bh_ra), .rdata(bh_rd));
	lbts_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_btail (.clk(clk), .we(bt_we),
		.waddr(bt_wa), .wdata(bt_wd), .raddr(bt_ra), .rdata(bt_rd));

	// Bucket of a tag: its low bits, folded once into range when ENTRIES is not a
	// power of two. Lookups compare the whole tag, so the choice of hash is free.
	function automatic logic [AW-1:0] bucket_of(input logic [TAG_BITS-1:0] tag);
		logic [AW:0] raw;
		raw = {1'b0, AW'(tag)};
		if (raw >= (AW + 1)'(ENTRIES)) begin
			raw = raw - (AW + 1)'(ENTRIES);
		end
		return raw[AW-1:0];
	endfunction

	logic [TAG_BITS-1:0] in_tag;
	logic [AW-1:0]       b_new, b_old, e_a;
	logic                in_idle;
	logic                imm_done;

	assign in_tag  = TAG_BITS'(req.slice_tag);
	assign b_new   = bucket_of(tag_q);
	assign b_old   = bucket_of(oldtag_q);
	assign e_a     = e_q[AW-1:0];
	assign in_idle = (state_q == S_IDLE);

	// Commands that finish without touching any memory: a lookup of the none marker,
	// an allocate with an empty recency list, a bind outside the store and an
	// unused opcode.
	always_comb begin
		case (req.opcode)
			OP_LOOKUP: imm_done = (in_tag == TAG_NONE);
			OP_ALLOC:  imm_done = (rtail_q == NIL);
			OP_BIND:   imm_done = ((IW + IDX_W)'(req.entry_index) >= (IW + IDX_W)'(ENTRIES));
			default:   imm_done = 1'b1;
		endcase
	end

	always_comb begin
		tag_we = 1'b0; rp_we = 1'b0; rn_we = 1'b0; cp_we = 1'b0;
		cn_we  = 1'b0; bh_we = 1'b0; bt_we = 1'b0;
		tag_wa = '0; rp_wa = '0; rn_wa = '0; cp_wa = '0; cn_wa = '0; bh_wa = '0; bt_wa = '0;
		tag_ra = '0; rp_ra = '0; rn_ra = '0; cp_ra = '0; cn_ra = '0; bh_ra = '0; bt_ra = '0;
		tag_wd = '0; rp_wd = '0; rn_wd = '0; cp_wd = '0; cn_wd = '0; bh_wd = '0; bt_wd = '0;
		case (state_q)
			S_CLEAR: begin
				tag_we = 1'b1; rp_we = 1'b1; rn_we = 1'b1; cp_we = 1'b1;
				cn_we  = 1'b1; bh_we = 1'b1; bt_we = 1'b1;
				tag_wa = clr_q; rp_wa = clr_q; rn_wa = clr_q; cp_wa = clr_q;
				cn_wa  = clr_q; bh_wa = clr_q; bt_wa = clr_q;
				tag_wd = TAG_NONE;
				rp_wd  = (clr_q == '0) ? NIL : IW'(clr_q) - IW'(1);
				rn_wd  = (clr_q == LAST) ? NIL : IW'(clr_q) + IW'(1);
				cp_wd  = NIL; cn_wd = NIL; bh_wd = NIL; bt_wd = NIL;
			end
			S_L_HEAD: bh_ra = b_new;
			S_L_CHK: begin
				tag_ra = cur_q[AW-1:0];
				cn_ra  = cur_q[AW-1:0];
			end
			S_AL_RD, S_B_RD: tag_ra = e_a;
			S_M_RD: begin
				rp_ra = e_a;
				rn_ra = e_a;
			end
			S_M_UNL: begin
				if (rp_rd < NIL) begin
					rn_we = 1'b1; rn_wa = rp_rd[AW-1:0]; rn_wd = rn_rd;
				end
				if (rn_rd < NIL) begin
					rp_we = 1'b1; rp_wa = rn_rd[AW-1:0]; rp_wd = rp_rd;
				end
			end
			S_M_LNK1: begin
				rp_we = 1'b1; rp_wa = e_a; rp_wd = NIL;
				rn_we = 1'b1; rn_wa = e_a; rn_wd = rhead_q;
			end
			S_M_LNK2: begin
				if (rhead_q < NIL) begin
					rp_we = 1'b1; rp_wa = rhead_q[AW-1:0]; rp_wd = e_q;
				end
			end
			S_CR_RD: begin
				cp_ra = e_a;
				cn_ra = e_a;
			end
			S_CR_UNL: begin
				if (cp_rd < NIL) begin
					cn_we = 1'b1; cn_wa = cp_rd[AW-1:0]; cn_wd = cn_rd;
				end else begin
					bh_we = 1'b1; bh_wa = b_old; bh_wd = cn_rd;
				end
				if (cn_rd < NIL) begin
					cp_we = 1'b1; cp_wa = cn_rd[AW-1:0]; cp_wd = cp_rd;
				end else begin
					bt_we = 1'b1; bt_wa = b_old; bt_wd = cp_rd;
				end
			end
			S_CR_CLR: begin
				cp_we = 1'b1; cp_wa = e_a; cp_wd = NIL;
				cn_we = 1'b1; cn_wa = e_a; cn_wd = NIL;
			end
			S_T_WR: begin
				tag_we = 1'b1;
				tag_wa = e_a;
				tag_wd = (op_q == OP_ALLOC) ? TAG_NONE : tag_q;
			end
			S_A_RD: bt_ra = b_new;
			S_A_WR1: begin
				cp_we = 1'b1; cp_wa = e_a; cp_wd = bt_rd;
				cn_we = 1'b1; cn_wa = e_a; cn_wd = NIL;
				bt_we = 1'b1; bt_wa = b_new; bt_wd = e_q;
			end
			S_A_WR2: begin
				if (t_q < NIL) begin
					cn_we = 1'b1; cn_wa = t_q[AW-1:0]; cn_wd = e_q;
				end else begin
					bh_we = 1'b1; bh_wa = b_new; bh_wd = e_q;
				end
			end
			default: ;
		endcase
	end

	// Completion of the recency move: lookups finish, allocations drop the victim
	// from its bucket chain when it still holds a tag.
	state_t post_mru_state;
	logic   post_mru_fin;

	always_comb begin
		post_mru_state = S_IDLE;
		post_mru_fin   = 1'b1;
		if (op_q == OP_ALLOC && oldtag_q != TAG_NONE) begin
			post_mru_state = S_CR_RD;
			post_mru_fin   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			rhead_q <= '0;
			rtail_q <= IW'(ENTRIES - 1);
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					// The strobe of the previous response drops here unless an
					// immediate command answers in the next cycle.
					done_q <= start && imm_done;
					if (start) begin
						op_q  <= req.opcode;
						tag_q <= in_tag;
						cnt_q <= '0;
						rsp_q <= '{status: (req.opcode == OP_LOOKUP) ? ST_MISS : ST_OK,
							buffer_index: '0};
						case (req.opcode)
							OP_LOOKUP: begin
								if (!imm_done) begin
									state_q <= S_L_HEAD;
								end
							end
							OP_ALLOC: begin
								e_q <= rtail_q;
								if (!imm_done) begin
									state_q <= S_AL_RD;
								end
							end
							OP_BIND: begin
								e_q <= IW'(req.entry_index);
								if (!imm_done) begin
									state_q <= S_B_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_L_HEAD: state_q <= S_L_LOAD;
				S_L_LOAD: begin
					cur_q   <= bh_rd;
					state_q <= S_L_CHK;
				end
				S_L_CHK: begin
					if (cur_q >= NIL || cnt_q == NIL) begin
						done_q  <= 1'b1;
						rsp_q   <= '{status: ST_MISS, buffer_index: '0};
						state_q <= S_IDLE;
					end else begin
						state_q <= S_L_CMP;
					end
				end
				S_L_CMP: begin
					if (tag_rd == tag_q) begin
						e_q     <= cur_q;
						state_q <= S_M_RD;
					end else begin
						cur_q   <= cn_rd;
						cnt_q   <= cnt_q + IW'(1);
						state_q <= S_L_CHK;
					end
				end
				S_AL_RD: state_q <= S_AL_TAG;
				S_AL_TAG: begin
					oldtag_q <= tag_rd;
					state_q  <= S_M_RD;
				end
				S_B_RD: state_q <= S_B_TAG;
				S_B_TAG: begin
					oldtag_q <= tag_rd;
					state_q  <= (tag_rd != TAG_NONE) ? S_CR_RD : S_T_WR;
				end
				S_M_RD: begin
					// An entry already at the most recent end stays where it is.
					if (rhead_q == e_q) begin
						state_q <= post_mru_state;
						if (post_mru_fin) begin
							done_q <= 1'b1;
							rsp_q  <= '{status: ST_OK, buffer_index: IDX_W'(e_q)};
						end
					end else begin
						state_q <= S_M_UNL;
					end
				end
				S_M_UNL: begin
					if (rp_rd >= NIL) begin
						rhead_q <= rn_rd;
					end
					if (rn_rd >= NIL) begin
						rtail_q <= rp_rd;
					end
					state_q <= S_M_LNK1;
				end
				S_M_LNK1: state_q <= S_M_LNK2;
				S_M_LNK2: begin
					if (rhead_q >= NIL) begin
						rtail_q <= e_q;
					end
					rhead_q <= e_q;
					state_q <= post_mru_state;
					if (post_mru_fin) begin
						done_q <= 1'b1;
						rsp_q  <= '{status: ST_OK, buffer_index: IDX_W'(e_q)};
					end
				end
				S_CR_RD:  state_q <= S_CR_UNL;
				S_CR_UNL: state_q <= S_CR_CLR;
				S_CR_CLR: state_q <= S_T_WR;
				S_T_WR: begin
					if (op_q == OP_BIND && tag_q != TAG_NONE) begin
						state_q <= S_A_RD;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						if (op_q == OP_ALLOC) begin
							rsp_q <= '{status: ST_OK, buffer_index: IDX_W'(e_q)};
						end
					end
				end
				S_A_RD: state_q <= S_A_WR1;
				S_A_WR1: begin
					t_q     <= bt_rd;
					state_q <= S_A_WR2;
				end
				S_A_WR2: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = !in_idle;
	assign done = done_q;
	assign rsp  = rsp_q;

	// A response is only ever shown while the sequencer is idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> in_idle)
		else $error("response issued while the sequencer is busy");

	// The recency list always holds every entry, so its ends are never empty.
	a_list_ends: assert property (@(posedge clk) disable iff (!arst_n)
		in_idle |-> (rhead_q < NIL && rtail_q < NIL))
		else $error("recency list end lost");

	// A lookup miss never carries an entry number.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status == ST_MISS) |-> (rsp.buffer_index == '0))
		else $error("miss response carries an index");

endmodule

[rtl/lbts_ram.sv]
// Generic single write port, single read port RAM with registered read data.
module lbts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
